### rtl/rbsd_pkg.sv
// shared types, constants and microprogram of the rigid body derivative core
package rbsd_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 20;
  localparam int MW        = 2 * WORD_BITS;
  localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int PROG_LEN  = 102;
  localparam int PC_W      = $clog2(PROG_LEN);
  localparam int TMP_DEPTH = 16;
  localparam int TMP_AW    = $clog2(TMP_DEPTH);
  localparam int CODE_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int FUNC_W    = 3;
  localparam int GROUP_W   = 2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-2:0]        uword_t;

  // load group codes
  localparam logic [FUNC_W-1:0] FUNC_POSITION = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_VELOCITY = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUAT     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SPIN     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FORCE    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_TORQUE   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MASS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IXX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IYY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IZZ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IXY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IXZ  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IYZ  = 3'd6;

  // result group codes
  localparam logic [GROUP_W-1:0] GRP_POS_RATE  = 2'd0;
  localparam logic [GROUP_W-1:0] GRP_ACCEL     = 2'd1;
  localparam logic [GROUP_W-1:0] GRP_QUAT_RATE = 2'd2;
  localparam logic [GROUP_W-1:0] GRP_ANG_ACCEL = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    word_t             comp_a;
    word_t             comp_b;
    word_t             comp_c;
    word_t             comp_d;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [GROUP_W-1:0] group;
    word_t              rate_a;
    word_t              rate_b;
    word_t              rate_c;
    word_t              rate_d;
    logic               end_of_run;
    logic               fault;
  } result_t;

  // loaded body state and configuration seen by the sequencer
  typedef struct packed {
    uword_t      body_mass;
    uword_t      inertia_xx;
    uword_t      inertia_yy;
    uword_t      inertia_zz;
    word_t       inertia_xy;
    word_t       inertia_xz;
    word_t       inertia_yz;
    word_t [2:0] vel;
    word_t [3:0] quat;
    word_t [2:0] spin;
    word_t [2:0] applied_force;
    word_t [2:0] torque;
  } bank_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_MULH, OP_DIV, OP_EMIT
  } op_t;

  // operand codes: fixed bank below 32, scratch memory at 32 and above
  typedef enum logic [CODE_W-1:0] {
    RC_ZERO = 6'd0,  RC_MASS = 6'd1,  RC_IXX = 6'd2,  RC_IYY = 6'd3,
    RC_IZZ  = 6'd4,  RC_IXY  = 6'd5,  RC_IXZ = 6'd6,  RC_IYZ = 6'd7,
    RC_V0   = 6'd8,  RC_V1   = 6'd9,  RC_V2  = 6'd10,
    RC_Q0   = 6'd11, RC_Q1   = 6'd12, RC_Q2  = 6'd13, RC_Q3  = 6'd14,
    RC_W0   = 6'd15, RC_W1   = 6'd16, RC_W2  = 6'd17,
    RC_F0   = 6'd18, RC_F1   = 6'd19, RC_F2  = 6'd20,
    RC_T0   = 6'd21, RC_T1   = 6'd22, RC_T2  = 6'd23,
    RC_R0   = 6'd24, RC_R1   = 6'd25, RC_R2  = 6'd26, RC_R3  = 6'd27,
    RC_DET  = 6'd28,
    RC_L0   = 6'd32, RC_L1   = 6'd33, RC_L2  = 6'd34,
    RC_U0   = 6'd35, RC_U1   = 6'd36, RC_U2  = 6'd37,
    RC_A00  = 6'd38, RC_A11  = 6'd39, RC_A22 = 6'd40,
    RC_A01  = 6'd41, RC_A02  = 6'd42, RC_A12 = 6'd43,
    RC_P    = 6'd44, RC_S    = 6'd45, RC_N   = 6'd46
  } reg_code_t;

  typedef struct packed {
    op_t                op;
    reg_code_t          dst;
    reg_code_t          src_a;
    reg_code_t          src_b;
    logic [GROUP_W-1:0] grp;
  } instr_t;

  typedef enum logic [1:0] {SQ_IDLE, SQ_FETCH, SQ_ISSUE, SQ_WAIT} seq_state_t;

  typedef enum logic [2:0] {AS_IDLE, AS_ADONE, AS_MRND, AS_DIV, AS_DRND} alu_state_t;

  function automatic instr_t mk(op_t op, reg_code_t d, reg_code_t a, reg_code_t b);
    instr_t i;
    i.op    = op;
    i.dst   = d;
    i.src_a = a;
    i.src_b = b;
    i.grp   = GRP_POS_RATE;
    return i;
  endfunction

  function automatic instr_t emit_i(logic [GROUP_W-1:0] g);
    instr_t i;
    i       = mk(OP_EMIT, RC_ZERO, RC_ZERO, RC_ZERO);
    i.grp   = g;
    return i;
  endfunction

  // microprogram: one run of the four derivative groups
  function automatic instr_t ucode(logic [PC_W-1:0] pc);
    instr_t i;
    unique case (pc)
      // position rate
      0:   i = mk(OP_ADD,  RC_R0, RC_V0, RC_ZERO);
      1:   i = mk(OP_ADD,  RC_R1, RC_V1, RC_ZERO);
      2:   i = mk(OP_ADD,  RC_R2, RC_V2, RC_ZERO);
      3:   i = mk(OP_ADD,  RC_R3, RC_ZERO, RC_ZERO);
      4:   i = emit_i(GRP_POS_RATE);
      // acceleration
      5:   i = mk(OP_DIV,  RC_R0, RC_F0, RC_MASS);
      6:   i = mk(OP_DIV,  RC_R1, RC_F1, RC_MASS);
      7:   i = mk(OP_DIV,  RC_R2, RC_F2, RC_MASS);
      8:   i = mk(OP_ADD,  RC_R3, RC_ZERO, RC_ZERO);
      9:   i = emit_i(GRP_ACCEL);
      // quaternion rate
      10:  i = mk(OP_MULH, RC_P,  RC_W0, RC_Q1);
      11:  i = mk(OP_SUB,  RC_S,  RC_ZERO, RC_P);
      12:  i = mk(OP_MULH, RC_P,  RC_W1, RC_Q2);
      13:  i = mk(OP_SUB,  RC_S,  RC_S,  RC_P);
      14:  i = mk(OP_MULH, RC_P,  RC_W2, RC_Q3);
      15:  i = mk(OP_SUB,  RC_R0, RC_S,  RC_P);
      16:  i = mk(OP_MULH, RC_S,  RC_W0, RC_Q0);
      17:  i = mk(OP_MULH, RC_P,  RC_W2, RC_Q2);
      18:  i = mk(OP_ADD,  RC_S,  RC_S,  RC_P);
      19:  i = mk(OP_MULH, RC_P,  RC_W1, RC_Q3);
      20:  i = mk(OP_SUB,  RC_R1, RC_S,  RC_P);
      21:  i = mk(OP_MULH, RC_S,  RC_W1, RC_Q0);
      22:  i = mk(OP_MULH, RC_P,  RC_W2, RC_Q1);
      23:  i = mk(OP_SUB,  RC_S,  RC_S,  RC_P);
      24:  i = mk(OP_MULH, RC_P,  RC_W0, RC_Q3);
      25:  i = mk(OP_ADD,  RC_R2, RC_S,  RC_P);
      26:  i = mk(OP_MULH, RC_S,  RC_W2, RC_Q0);
      27:  i = mk(OP_MULH, RC_P,  RC_W1, RC_Q1);
      28:  i = mk(OP_ADD,  RC_S,  RC_S,  RC_P);
      29:  i = mk(OP_MULH, RC_P,  RC_W0, RC_Q2);
      30:  i = mk(OP_SUB,  RC_R3, RC_S,  RC_P);
      31:  i = emit_i(GRP_QUAT_RATE);
      // angular momentum
      32:  i = mk(OP_MUL,  RC_S,  RC_IXX, RC_W0);
      33:  i = mk(OP_MUL,  RC_P,  RC_IXY, RC_W1);
      34:  i = mk(OP_ADD,  RC_S,  RC_S,  RC_P);
      35:  i = mk(OP_MUL,  RC_P,  RC_IXZ, RC_W2);
      36:  i = mk(OP_ADD,  RC_L0, RC_S,  RC_P);
      37:  i = mk(OP_MUL,  RC_S,  RC_IXY, RC_W0);
      38:  i = mk(OP_MUL,  RC_P,  RC_IYY, RC_W1);
      39:  i = mk(OP_ADD,  RC_S,  RC_S,  RC_P);
      40:  i = mk(OP_MUL,  RC_P,  RC_IYZ, RC_W2);
      41:  i = mk(OP_ADD,  RC_L1, RC_S,  RC_P);
      42:  i = mk(OP_MUL,  RC_S,  RC_IXZ, RC_W0);
      43:  i = mk(OP_MUL,  RC_P,  RC_IYZ, RC_W1);
      44:  i = mk(OP_ADD,  RC_S,  RC_S,  RC_P);
      45:  i = mk(OP_MUL,  RC_P,  RC_IZZ, RC_W2);
      46:  i = mk(OP_ADD,  RC_L2, RC_S,  RC_P);
      // torque less gyroscopic term
      47:  i = mk(OP_MUL,  RC_S,  RC_W1, RC_L2);
      48:  i = mk(OP_MUL,  RC_P,  RC_W2, RC_L1);
      49:  i = mk(OP_SUB,  RC_S,  RC_S,  RC_P);
      50:  i = mk(OP_SUB,  RC_U0, RC_T0, RC_S);
      51:  i = mk(OP_MUL,  RC_S,  RC_W2, RC_L0);
      52:  i = mk(OP_MUL,  RC_P,  RC_W0, RC_L2);
      53:  i = mk(OP_SUB,  RC_S,  RC_S,  RC_P);
      54:  i = mk(OP_SUB,  RC_U1, RC_T1, RC_S);
      55:  i = mk(OP_MUL,  RC_S,  RC_W0, RC_L1);
      56:  i = mk(OP_MUL,  RC_P,  RC_W1, RC_L0);
      57:  i = mk(OP_SUB,  RC_S,  RC_S,  RC_P);
      58:  i = mk(OP_SUB,  RC_U2, RC_T2, RC_S);
      // adjugate of the inertia tensor
      59:  i = mk(OP_MUL,  RC_S,  RC_IYY, RC_IZZ);
      60:  i = mk(OP_MUL,  RC_P,  RC_IYZ, RC_IYZ);
      61:  i = mk(OP_SUB,  RC_A00, RC_S, RC_P);
      62:  i = mk(OP_MUL,  RC_S,  RC_IXX, RC_IZZ);
      63:  i = mk(OP_MUL,  RC_P,  RC_IXZ, RC_IXZ);
      64:  i = mk(OP_SUB,  RC_A11, RC_S, RC_P);
      65:  i = mk(OP_MUL,  RC_S,  RC_IXX, RC_IYY);
      66:  i = mk(OP_MUL,  RC_P,  RC_IXY, RC_IXY);
      67:  i = mk(OP_SUB,  RC_A22, RC_S, RC_P);
      68:  i = mk(OP_MUL,  RC_S,  RC_IXZ, RC_IYZ);
      69:  i = mk(OP_MUL,  RC_P,  RC_IXY, RC_IZZ);
      70:  i = mk(OP_SUB,  RC_A01, RC_S, RC_P);
      71:  i = mk(OP_MUL,  RC_S,  RC_IXY, RC_IYZ);
      72:  i = mk(OP_MUL,  RC_P,  RC_IXZ, RC_IYY);
      73:  i = mk(OP_SUB,  RC_A02, RC_S, RC_P);
      74:  i = mk(OP_MUL,  RC_S,  RC_IXY, RC_IXZ);
      75:  i = mk(OP_MUL,  RC_P,  RC_IXX, RC_IYZ);
      76:  i = mk(OP_SUB,  RC_A12, RC_S, RC_P);
      // determinant
      77:  i = mk(OP_MUL,  RC_S,  RC_IXX, RC_A00);
      78:  i = mk(OP_MUL,  RC_P,  RC_IXY, RC_A01);
      79:  i = mk(OP_ADD,  RC_S,  RC_S,  RC_P);
      80:  i = mk(OP_MUL,  RC_P,  RC_IXZ, RC_A02);
      81:  i = mk(OP_ADD,  RC_DET, RC_S, RC_P);
      // angular acceleration
      82:  i = mk(OP_MUL,  RC_S,  RC_A00, RC_U0);
      83:  i = mk(OP_MUL,  RC_P,  RC_A01, RC_U1);
      84:  i = mk(OP_ADD,  RC_S,  RC_S,  RC_P);
      85:  i = mk(OP_MUL,  RC_P,  RC_A02, RC_U2);
      86:  i = mk(OP_ADD,  RC_N,  RC_S,  RC_P);
      87:  i = mk(OP_DIV,  RC_R0, RC_N,  RC_DET);
      88:  i = mk(OP_MUL,  RC_S,  RC_A01, RC_U0);
      89:  i = mk(OP_MUL,  RC_P,  RC_A11, RC_U1);
      90:  i = mk(OP_ADD,  RC_S,  RC_S,  RC_P);
      91:  i = mk(OP_MUL,  RC_P,  RC_A12, RC_U2);
      92:  i = mk(OP_ADD,  RC_N,  RC_S,  RC_P);
      93:  i = mk(OP_DIV,  RC_R1, RC_N,  RC_DET);
      94:  i = mk(OP_MUL,  RC_S,  RC_A02, RC_U0);
      95:  i = mk(OP_MUL,  RC_P,  RC_A12, RC_U1);
      96:  i = mk(OP_ADD,  RC_S,  RC_S,  RC_P);
      97:  i = mk(OP_MUL,  RC_P,  RC_A22, RC_U2);
      98:  i = mk(OP_ADD,  RC_N,  RC_S,  RC_P);
      99:  i = mk(OP_DIV,  RC_R2, RC_N,  RC_DET);
      100: i = mk(OP_ADD,  RC_R3, RC_ZERO, RC_ZERO);
      default: i = emit_i(GRP_ANG_ACCEL);
    endcase
    return i;
  endfunction

endpackage

### rtl/rigid_body_state_derivative_core.sv
// top level: configuration registers, state loading and derivative sequencer
//
// Items with start load one state group each (a position item loads none). An item
// with last set then starts a run, during which busy is high and no item is
// taken; the run is spent in one shared arithmetic unit driven by a microprogram
// of add/subtract, multiply and six divide steps, the divider resolving one quotient
// bit per cycle. The four results (groups 0 to 3) each appear for a single cycle on
// result with result_valid high and must be captured then; the receiver cannot
// stall them. end_of_run marks group 3. Configuration is always accepted (cfg_ready
// high) and should only be written while busy is low.
module rigid_body_state_derivative_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  rbsd_pkg::item_t                     item,
  output logic                                result_valid,
  output rbsd_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rbsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbsd_pkg::WORD_BITS-1:0]      cfg_data
);
  import rbsd_pkg::*;

  bank_t bank;
  logic  take;

  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  // configuration registers and state group loading
  always_ff @(posedge clk) begin
    if (rst) begin
      bank.body_mass     <= '0;
      bank.inertia_xx    <= '0;
      bank.inertia_yy    <= '0;
      bank.inertia_zz    <= '0;
      bank.inertia_xy    <= '0;
      bank.inertia_xz    <= '0;
      bank.inertia_yz    <= '0;
      bank.vel           <= '0;
      bank.quat          <= '0;
      bank.spin          <= '0;
      bank.applied_force <= '0;
      bank.torque        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MASS: bank.body_mass  <= cfg_data[WORD_BITS-2:0];
          CFG_IXX:  bank.inertia_xx <= cfg_data[WORD_BITS-2:0];
          CFG_IYY:  bank.inertia_yy <= cfg_data[WORD_BITS-2:0];
          CFG_IZZ:  bank.inertia_zz <= cfg_data[WORD_BITS-2:0];
          CFG_IXY:  bank.inertia_xy <= cfg_data;
          CFG_IXZ:  bank.inertia_xz <= cfg_data;
          CFG_IYZ:  bank.inertia_yz <= cfg_data;
          default:  ;
        endcase
      end
      // state group loading on an input transfer
      if (take) begin
        unique case (item.func)
          FUNC_VELOCITY: bank.vel    <= {item.comp_c, item.comp_b, item.comp_a};
          FUNC_QUAT:     bank.quat   <= {item.comp_d, item.comp_c, item.comp_b, item.comp_a};
          FUNC_SPIN:     bank.spin   <= {item.comp_c, item.comp_b, item.comp_a};
          FUNC_FORCE:    bank.applied_force <= {item.comp_c, item.comp_b, item.comp_a};
          FUNC_TORQUE:   bank.torque <= {item.comp_c, item.comp_b, item.comp_a};
          FUNC_POSITION: ;
          default:       ;
        endcase
      end
    end
  end

  rbsd_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .run          (take && item.last),
    .bank         (bank),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

### rtl/rbsd_alu.sv
// shared saturating add/subtract, rounding multiply and restoring divide unit
module rbsd_alu (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  rbsd_pkg::op_t  op,
  input  rbsd_pkg::word_t a,
  input  rbsd_pkg::word_t b,
  output logic          done,
  output rbsd_pkg::word_t res,
  output logic          sat
);
  import rbsd_pkg::*;

  localparam int W = WORD_BITS;

  alu_state_t           state, state_next;
  word_t                add_res;
  logic                 add_sat;
  logic [MW-1:0]        prod;
  logic                 neg;
  logic                 sh21;
  logic [DIV_STEPS-1:0] dq;
  logic [W-1:0]         rem;
  logic [W-1:0]         dvs;
  logic [CNT_W-1:0]     cnt;

  logic [W-1:0]   ua, ub;
  logic [W:0]     a_ext, b_ext, sum;
  logic           ovf;
  logic [W:0]     trial, trial_sub;
  logic           ge;
  logic [MW:0]    rnd;
  logic [MW:0]    mshift;
  logic [MW-1:0]  qv;
  logic           rup;
  logic [W:0]     mul_pk, div_pk;

  // clamp a magnitude to the word and apply the sign
  function automatic logic [W:0] pack(logic ng, logic [MW-1:0] m);
    logic [MW-1:0] lim;
    logic [W-1:0]  v;
    logic          s;
    lim = {{W{1'b0}}, ng, {(W-1){~ng}}};
    s   = m > lim;
    v   = s ? lim[W-1:0] : m[W-1:0];
    return {s, ng ? (~v + 1'b1) : v};
  endfunction

  // operand magnitudes, add/subtract with overflow
  always_comb begin
    ua    = a[W-1] ? (~a + 1'b1) : a;
    ub    = b[W-1] ? (~b + 1'b1) : b;
    a_ext = {a[W-1], a};
    b_ext = {b[W-1], b};
    sum   = (op == OP_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
    ovf   = sum[W] ^ sum[W-1];
  end

  // one restoring divide step
  always_comb begin
    trial     = {rem, dq[DIV_STEPS-1]};
    trial_sub = trial - {1'b0, dvs};
    ge        = trial >= {1'b0, dvs};
  end

  // rounding of product and quotient
  always_comb begin
    rnd    = {1'b0, prod} + ((MW+1)'(1) << (sh21 ? FRAC_BITS : FRAC_BITS - 1));
    mshift = rnd >> (sh21 ? FRAC_BITS + 1 : FRAC_BITS);
    mul_pk = pack(neg, mshift[MW-1:0]);
    rup    = {rem, 1'b0} >= {1'b0, dvs};
    qv     = {{(MW-DIV_STEPS){1'b0}}, dq} + MW'(rup);
    div_pk = pack(neg, qv);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      AS_IDLE: begin
        if (go) begin
          unique case (op)
            OP_ADD, OP_SUB:  state_next = AS_ADONE;
            OP_MUL, OP_MULH: state_next = AS_MRND;
            OP_DIV:          state_next = AS_DIV;
            default:         state_next = AS_IDLE;
          endcase
        end
      end
      AS_DIV:   if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = AS_DRND;
      AS_ADONE, AS_MRND, AS_DRND: state_next = AS_IDLE;
      default:  state_next = AS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done = 1'b0;
    res  = add_res;
    sat  = 1'b0;
    unique case (state)
      AS_ADONE: begin
        done = 1'b1;
        sat  = add_sat;
      end
      AS_MRND: begin
        done = 1'b1;
        res  = mul_pk[W-1:0];
        sat  = mul_pk[W];
      end
      AS_DRND: begin
        done = 1'b1;
        res  = div_pk[W-1:0];
        sat  = div_pk[W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= AS_IDLE;
    else     state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == AS_IDLE && go) begin
      add_res <= ovf ? {sum[W], {(W-1){~sum[W]}}} : sum[W-1:0];
      add_sat <= ovf;
      prod    <= ua * ub;
      neg     <= a[W-1] ^ b[W-1];
      sh21    <= (op == OP_MULH);
      dq      <= {ua, {FRAC_BITS{1'b0}}};
      dvs     <= ub;
      rem     <= '0;
      cnt     <= '0;
    end else if (state == AS_DIV) begin
      rem <= ge ? trial_sub[W-1:0] : trial[W-1:0];
      dq  <= {dq[DIV_STEPS-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

### rtl/rbsd_seq.sv
// microprogram sequencer, scratch memory and result register
module rbsd_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              run,
  input  rbsd_pkg::bank_t   bank,
  output logic              busy,
  output logic              result_valid,
  output rbsd_pkg::result_t result
);
  import rbsd_pkg::*;

  seq_state_t       state, state_next;
  logic [PC_W-1:0]  pc;
  instr_t           cur, instr;
  word_t            opa, opb;
  word_t [3:0]      rr;
  word_t            det;
  logic             sat_acc;
  word_t            tmem [TMP_DEPTH];

  logic   alu_go, alu_done, alu_sat, emit, wr;
  word_t  alu_res;
  logic   zero_out;

  function automatic word_t fixed_val(bank_t bk, word_t [3:0] r, word_t dt, reg_code_t c);
    word_t v;
    unique case (c)
      RC_MASS: v = word_t'({1'b0, bk.body_mass});
      RC_IXX:  v = word_t'({1'b0, bk.inertia_xx});
      RC_IYY:  v = word_t'({1'b0, bk.inertia_yy});
      RC_IZZ:  v = word_t'({1'b0, bk.inertia_zz});
      RC_IXY:  v = bk.inertia_xy;
      RC_IXZ:  v = bk.inertia_xz;
      RC_IYZ:  v = bk.inertia_yz;
      RC_V0:   v = bk.vel[0];
      RC_V1:   v = bk.vel[1];
      RC_V2:   v = bk.vel[2];
      RC_Q0:   v = bk.quat[0];
      RC_Q1:   v = bk.quat[1];
      RC_Q2:   v = bk.quat[2];
      RC_Q3:   v = bk.quat[3];
      RC_W0:   v = bk.spin[0];
      RC_W1:   v = bk.spin[1];
      RC_W2:   v = bk.spin[2];
      RC_F0:   v = bk.applied_force[0];
      RC_F1:   v = bk.applied_force[1];
      RC_F2:   v = bk.applied_force[2];
      RC_T0:   v = bk.torque[0];
      RC_T1:   v = bk.torque[1];
      RC_T2:   v = bk.torque[2];
      RC_R0:   v = r[0];
      RC_R1:   v = r[1];
      RC_R2:   v = r[2];
      RC_R3:   v = r[3];
      RC_DET:  v = dt;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign cur = ucode(pc);

  rbsd_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .go   (alu_go),
    .op   (instr.op),
    .a    (opa),
    .b    (opb),
    .done (alu_done),
    .res  (alu_res),
    .sat  (alu_sat)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      SQ_IDLE:  if (run) state_next = SQ_FETCH;
      SQ_FETCH: state_next = SQ_ISSUE;
      SQ_ISSUE: begin
        if (instr.op == OP_EMIT) begin
          state_next = (instr.grp == GRP_ANG_ACCEL) ? SQ_IDLE : SQ_FETCH;
        end else begin
          state_next = SQ_WAIT;
        end
      end
      SQ_WAIT:  if (alu_done) state_next = SQ_FETCH;
      default:  state_next = SQ_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    alu_go   = (state == SQ_ISSUE) && (instr.op != OP_EMIT);
    emit     = (state == SQ_ISSUE) && (instr.op == OP_EMIT);
    wr       = (state == SQ_WAIT) && alu_done;
    busy     = (state != SQ_IDLE) || result_valid;
    zero_out = ((instr.grp == GRP_ACCEL) && (bank.body_mass == '0)) ||
               ((instr.grp == GRP_ANG_ACCEL) && (det == '0));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= SQ_IDLE;
      pc           <= '0;
      sat_acc      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      if (run && state == SQ_IDLE) begin
        pc      <= '0;
        sat_acc <= 1'b0;
      end else if (emit) begin
        pc      <= pc + 1'b1;
        sat_acc <= 1'b0;
      end else if (wr) begin
        pc      <= pc + 1'b1;
        sat_acc <= sat_acc | alu_sat;
      end
    end
  end

  // operand fetch from scratch memory or fixed bank
  always_ff @(posedge clk) begin
    if (state == SQ_FETCH) begin
      instr <= cur;
      opa   <= cur.src_a[CODE_W-1] ? tmem[cur.src_a[TMP_AW-1:0]]
                                   : fixed_val(bank, rr, det, cur.src_a);
      opb   <= cur.src_b[CODE_W-1] ? tmem[cur.src_b[TMP_AW-1:0]]
                                   : fixed_val(bank, rr, det, cur.src_b);
    end
  end

  // scratch memory write
  always_ff @(posedge clk) begin
    if (wr && instr.dst[CODE_W-1]) tmem[instr.dst[TMP_AW-1:0]] <= alu_res;
  end

  // result and determinant registers
  always_ff @(posedge clk) begin
    if (wr) begin
      unique case (instr.dst)
        RC_R0:   rr[0] <= alu_res;
        RC_R1:   rr[1] <= alu_res;
        RC_R2:   rr[2] <= alu_res;
        RC_R3:   rr[3] <= alu_res;
        RC_DET:  det   <= alu_res;
        default: ;
      endcase
    end
  end

  // result transfer register
  always_ff @(posedge clk) begin
    if (emit) begin
      result.group      <= instr.grp;
      result.rate_a     <= zero_out ? '0 : rr[0];
      result.rate_b     <= zero_out ? '0 : rr[1];
      result.rate_c     <= zero_out ? '0 : rr[2];
      result.rate_d     <= zero_out ? '0 : rr[3];
      result.end_of_run <= (instr.grp == GRP_ANG_ACCEL);
      result.fault      <= sat_acc | zero_out;
    end
  end

endmodule

### rtl/rbsd_checker.sv
// port-level checks on the derivative core, bound to the top level
module rbsd_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input rbsd_pkg::item_t   item,
  input logic              result_valid,
  input rbsd_pkg::result_t result
);
  import rbsd_pkg::*;

  // results only come out during a run
  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result outside a run");

  // the closing result ends the run
  a_end_frees: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.end_of_run |=> !busy) else $error("busy after end of run");

  // only group 3 closes a run
  a_end_group: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.group != GRP_ANG_ACCEL |-> !result.end_of_run)
    else $error("end of run on wrong group");

  // a plain load starts no run
  a_load_only: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !item.last |=> !busy && !result_valid)
    else $error("run started by plain load");

endmodule

bind rigid_body_state_derivative_core rbsd_checker u_rbsd_checker (.*);
